@@ design/bscf_pkg.sv @@
// Package for the bitmap set/clear/find block: field widths, function codes,
// configuration register indexes and the set-count limit.
// No dependencies.
package bscf_pkg;

    localparam int FUNC_W    = 3;
    localparam int IDX_W     = 32;
    localparam int CNT_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX = 13'h1FFF;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_GET        = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET        = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FIND_SET   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FIND_CLEAR = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_REFILL     = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOWEST_BIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHEST_BIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_ONES   = 2'd2;

    typedef logic [IDX_W-1:0] index_t;
    typedef logic [CNT_W-1:0] count_t;

endpackage

@@ design/bscf_req_if.sv @@
// Request channel of the bitmap block: valid/ready plus function and bit index.
// Depends on bscf_pkg.
interface bscf_req_if;
    import bscf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [IDX_W-1:0]  bit_index;

    modport source (output valid, func, bit_index, input ready);
    modport sink   (input valid, func, bit_index, output ready);
endinterface

@@ design/bscf_rsp_if.sv @@
// Response channel of the bitmap block: valid/ready plus status, bit value,
// found index and set count. Depends on bscf_pkg.
interface bscf_rsp_if;
    import bscf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     status;
    logic                     bit_value;
    logic signed [IDX_W-1:0]  found_index;
    logic [CNT_W-1:0]         ones_count;

    modport source (output valid, status, bit_value, found_index, ones_count, input ready);
    modport sink   (input valid, status, bit_value, found_index, ones_count, output ready);
endinterface

@@ design/bscf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bscf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ design/bscf_div.sv @@
// Splits a bit offset into word address and bit position by reciprocal
// multiplication (exact for every offset below 2**OFF_W). No dependencies.
module bscf_div #(
    parameter int WORD_BITS = 32,
    parameter int OFF_W     = 12,
    parameter int AW        = 7
) (
    input  logic                           clk,
    input  logic                           load,
    input  logic [OFF_W-1:0]               off,
    output logic [AW-1:0]                  word,
    output logic [AW-1:0]                  word_q,
    output logic [$clog2(WORD_BITS)-1:0]   bit_pos
);
    localparam int BW = $clog2(WORD_BITS);
    localparam int K  = OFF_W + BW;
    localparam int M  = ((1 << K) + WORD_BITS - 1) / WORD_BITS;
    localparam int MW = $clog2(M + 1);
    localparam int PW = OFF_W + MW;

    logic [PW-1:0]    prod;
    logic [OFF_W-1:0] off_reg;
    logic [AW-1:0]    word_reg;
    logic [OFF_W-1:0] base;

    assign prod = PW'(off) * PW'(M);
    assign word = AW'(prod >> K);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            off_reg  <= off;
            word_reg <= word;
        end
    end

    // remainder is below WORD_BITS, so the low bits of the difference suffice
    assign base    = OFF_W'(OFF_W'(word_reg) * OFF_W'(WORD_BITS));
    assign bit_pos = BW'(off_reg - base);
    assign word_q  = word_reg;
endmodule

@@ design/bscf_scan.sv @@
// Finds the lowest bit of one map word that matches the wanted value, among
// the bits still inside the span. No dependencies.
module bscf_scan #(
    parameter int WORD_BITS = 32,
    parameter int SPAN_W    = 13
) (
    input  logic [WORD_BITS-1:0]          word,
    input  logic                          want,
    input  logic [SPAN_W-1:0]             rem,
    output logic                          hit,
    output logic [$clog2(WORD_BITS)-1:0]  pos
);
    localparam int BW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] match;

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            match[b] = ((want ? word[b] : ~word[b]) == 1'b1) && (32'(b) < 32'(rem));
        end
    end

    always_comb
    begin
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (match[b])
            begin
                pos = BW'(b);
            end
        end
    end

    assign hit = |match;
endmodule

@@ design/bitmap_set_clear_find_core.sv @@
// Top level of the bitmap set/clear/find block: sequencer, count and config.
// Depends on bscf_pkg, bscf_req_if, bscf_rsp_if, bscf_ram, bscf_div, bscf_scan.
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+-------------------------------------------
//  req     | in  | valid/ready   | func, bit_index
//  rsp     | out | valid/ready   | status, bit_value, found_index, ones_count
//  cfg     | in  | cfg_we        | cfg_idx, cfg_data (lowest, highest, fill)
//
// Get/set/clear: an address step, then read-modify-write on the one map RAM
// port pair. Find: walks the map word by word, the check of each word
// overlapping the read of the next. Refill: one RAM write per word.
// After reset the map RAM is cleared word by word, and req.ready stays low
// meanwhile. A result waits in the output register; a new request is taken
// while it waits, and the block stalls on completion if it is unread.
module bitmap_set_clear_find_core #(
    parameter int CAPACITY_WORDS = 128,
    parameter int WORD_BITS      = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bscf_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [bscf_pkg::CFG_W-1:0]     cfg_data,
    bscf_req_if.sink                      req,
    bscf_rsp_if.source                    rsp
);
    import bscf_pkg::*;

    localparam int CAP_BITS = CAPACITY_WORDS * WORD_BITS;
    localparam int OFF_W    = $clog2(CAP_BITS);
    localparam int SPAN_W   = OFF_W + 1;
    localparam int AW       = (CAPACITY_WORDS > 1) ? $clog2(CAPACITY_WORDS) : 1;
    localparam int BW       = $clog2(WORD_BITS);

    localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY_WORDS - 1);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_FILL = 3'd0;
    localparam logic [ST_W-1:0] S_IDLE = 3'd1;
    localparam logic [ST_W-1:0] S_ADDR = 3'd2;
    localparam logic [ST_W-1:0] S_RMW  = 3'd3;
    localparam logic [ST_W-1:0] S_FIND = 3'd4;
    localparam logic [ST_W-1:0] S_BAD  = 3'd5;

    // configuration
    index_t lo_reg;
    index_t hi_reg;
    logic   fill_ones_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [SPAN_W-1:0] span_next;
    logic [IDX_W+1:0]  span_diff;

    // control
    logic [ST_W-1:0] state_reg, state_next;
    logic            init_reg, init_next;
    count_t          total_reg, total_next;
    logic [AW-1:0]   rd_addr_reg, rd_addr_next;
    logic [SPAN_W-1:0] rd_base_reg, rd_base_next;
    logic            chk_valid_reg, chk_valid_next;
    logic            out_valid_reg, out_valid_next;

    // payload
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [IDX_W:0]    off_reg, off_next;
    logic              ok_reg, ok_next;
    logic              want_reg, want_next;
    index_t            rd_idx_reg, rd_idx_next;
    index_t            chk_idx_reg, chk_idx_next;
    logic [SPAN_W-1:0] chk_base_reg, chk_base_next;
    logic              out_status_reg;
    logic              out_bit_reg;
    index_t            out_found_reg;
    count_t            out_count_reg;

    // result of the current cycle
    logic   emit;
    logic   res_status;
    logic   res_bit;
    index_t res_found;

    // RAM
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    // datapath helpers
    logic                 div_load;
    logic [AW-1:0]        div_word, div_word_q;
    logic [BW-1:0]        div_bit;
    logic                 scan_hit;
    logic [BW-1:0]        scan_pos;
    logic [SPAN_W-1:0]    scan_rem;
    logic                 slot_free;
    logic                 in_range;
    logic                 cur;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 more;
    logic                 hit_now;
    count_t               fill_count;

    bscf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bscf_div #(
        .WORD_BITS (WORD_BITS),
        .OFF_W     (OFF_W),
        .AW        (AW)
    ) u_div (
        .clk     (clk),
        .load    (div_load),
        .off     (off_reg[OFF_W-1:0]),
        .word    (div_word),
        .word_q  (div_word_q),
        .bit_pos (div_bit)
    );

    bscf_scan #(
        .WORD_BITS (WORD_BITS),
        .SPAN_W    (SPAN_W)
    ) u_scan (
        .word (ram_rdata),
        .want (want_reg),
        .rem  (scan_rem),
        .hit  (scan_hit),
        .pos  (scan_pos)
    );

    // Span of valid bits: clamp to zero and to the built capacity
    assign span_diff = {{2{hi_reg[IDX_W-1]}}, hi_reg} - {{2{lo_reg[IDX_W-1]}}, lo_reg}
                       + (IDX_W+2)'(1);

    always_comb
    begin
        if (span_diff[IDX_W+1])
        begin
            span_next = '0;
        end
        else if (span_diff > (IDX_W+2)'(CAP_BITS))
        begin
            span_next = SPAN_W'(CAP_BITS);
        end
        else
        begin
            span_next = SPAN_W'(span_diff);
        end
    end

    assign fill_count = (32'(span_reg) > 32'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(span_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg        <= '0;
            hi_reg        <= IDX_W'(4095);
            fill_ones_reg <= 1'b0;
            span_reg      <= '0;
        end
        else
        begin
            span_reg <= span_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_LOWEST_BIT:  lo_reg        <= cfg_data;
                    REG_HIGHEST_BIT: hi_reg        <= cfg_data;
                    REG_FILL_ONES:   fill_ones_reg <= cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign in_range  = !off_reg[IDX_W] && (off_reg[IDX_W-1:0] < IDX_W'(span_reg));
    assign cur       = ram_rdata[div_bit];
    assign bit_mask  = WORD_BITS'(1) << div_bit;
    assign more      = rd_base_reg < span_reg;
    assign hit_now   = chk_valid_reg && scan_hit;
    assign scan_rem  = span_reg - chk_base_reg;

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        total_next     = total_reg;
        rd_addr_next   = rd_addr_reg;
        rd_base_next   = rd_base_reg;
        chk_valid_next = chk_valid_reg;
        func_next      = func_reg;
        off_next       = off_reg;
        ok_next        = ok_reg;
        want_next      = want_reg;
        rd_idx_next    = rd_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_base_next  = chk_base_reg;

        ram_we    = 1'b0;
        ram_waddr = rd_addr_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = rd_addr_reg;
        div_load  = 1'b0;

        emit       = 1'b0;
        res_status = 1'b1;
        res_bit    = 1'b0;
        res_found  = '0;

        case (state_reg)
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = (!init_reg && fill_ones_reg) ? '1 : '0;
                if (rd_addr_reg != LAST_ADDR)
                begin
                    rd_addr_next = rd_addr_reg + 1'b1;
                end
                else if (init_reg)
                begin
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else if (slot_free)
                begin
                    emit       = 1'b1;
                    res_status = 1'b0;
                    total_next = fill_ones_reg ? fill_count : '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next = req.func;
                    off_next  = {req.bit_index[IDX_W-1], req.bit_index}
                                - {lo_reg[IDX_W-1], lo_reg};
                    case (req.func)
                        FUNC_GET, FUNC_SET, FUNC_CLEAR:
                        begin
                            state_next = S_ADDR;
                        end
                        FUNC_FIND_SET, FUNC_FIND_CLEAR:
                        begin
                            want_next      = (req.func == FUNC_FIND_SET);
                            rd_addr_next   = '0;
                            rd_base_next   = '0;
                            rd_idx_next    = lo_reg;
                            chk_valid_next = 1'b0;
                            state_next     = S_FIND;
                        end
                        FUNC_REFILL:
                        begin
                            rd_addr_next = '0;
                            state_next   = S_FILL;
                        end
                        default:
                        begin
                            state_next = S_BAD;
                        end
                    endcase
                end
            end

            S_ADDR:
            begin
                ram_re     = 1'b1;
                ram_raddr  = div_word;
                div_load   = 1'b1;
                ok_next    = in_range;
                state_next = S_RMW;
            end

            S_RMW:
            begin
                // hold everything, read data included, until the output slot frees
                if (slot_free)
                begin
                    emit       = 1'b1;
                    res_status = !ok_reg;
                    ram_waddr  = div_word_q;
                    if (ok_reg)
                    begin
                        case (func_reg)
                            FUNC_GET:
                            begin
                                res_bit = cur;
                            end
                            FUNC_SET:
                            begin
                                if (!cur)
                                begin
                                    ram_we    = 1'b1;
                                    ram_wdata = ram_rdata | bit_mask;
                                    if (total_reg != COUNT_MAX)
                                    begin
                                        total_next = total_reg + 1'b1;
                                    end
                                end
                            end
                            FUNC_CLEAR:
                            begin
                                if (cur)
                                begin
                                    ram_we    = 1'b1;
                                    ram_wdata = ram_rdata & ~bit_mask;
                                    if (total_reg != '0)
                                    begin
                                        total_next = total_reg - 1'b1;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                    state_next = S_IDLE;
                end
            end

            S_FIND:
            begin
                // read of the next word overlaps the check of the previous one
                if (hit_now || !more)
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        res_status = !hit_now;
                        res_found  = hit_now ? (chk_idx_reg + IDX_W'(scan_pos)) : '0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ram_re         = 1'b1;
                    rd_addr_next   = rd_addr_reg + 1'b1;
                    rd_base_next   = rd_base_reg + SPAN_W'(WORD_BITS);
                    rd_idx_next    = rd_idx_reg + IDX_W'(WORD_BITS);
                    chk_valid_next = 1'b1;
                    chk_base_next  = rd_base_reg;
                    chk_idx_next   = rd_idx_reg;
                end
            end

            S_BAD:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = emit ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            init_reg      <= 1'b1;
            total_reg     <= '0;
            rd_addr_reg   <= '0;
            rd_base_reg   <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            total_reg     <= total_next;
            rd_addr_reg   <= rd_addr_next;
            rd_base_reg   <= rd_base_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        off_reg      <= off_next;
        ok_reg       <= ok_next;
        want_reg     <= want_next;
        rd_idx_reg   <= rd_idx_next;
        chk_idx_reg  <= chk_idx_next;
        chk_base_reg <= chk_base_next;
        if (emit)
        begin
            out_status_reg <= res_status;
            out_bit_reg    <= res_bit;
            out_found_reg  <= res_found;
            out_count_reg  <= total_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.bit_value   = out_bit_reg;
    assign rsp.found_index = out_found_reg;
    assign rsp.ones_count  = out_count_reg;

    // Map is written only by the fill sweep or by an in-range bit update
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_FILL) || ((state_reg == S_RMW) && ok_reg))
        else $error("map write outside fill sweep or in-range update");

    a_no_read_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("map read and write in the same cycle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) != S_IDLE))
        else $error("result raised without a request in progress");
endmodule

@@ tb/sv/tb_bitmap_set_clear_find_core.sv @@
`timescale 1ns / 100ps
// Self-checking bench for bitmap_set_clear_find_core: drives request words, mirrors the
// bitmap, range and set count, and checks each response word in order.
// Depends on bscf_pkg, bscf_req_if, bscf_rsp_if and the core.
module tb_bitmap_set_clear_find_core;
    import bscf_pkg::*;

    localparam int CAPACITY_WORDS = 128;
    localparam int WORD_BITS      = 32;
    localparam int MAP_BITS       = CAPACITY_WORDS * WORD_BITS;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PER_PHASE = 120;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_DATA = 1'b1;

    // Codes six and seven are not assigned to any function
    localparam logic [FUNC_W-1:0] FUNC_RSVD_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        index_t            bit_index;
    } req_word_t;

    typedef struct packed {
        logic       status;
        logic       bit_value;
        index_t     found_index;
        count_t     ones_count;
    } rsp_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    bscf_req_if req_ch ();
    bscf_rsp_if rsp_ch ();

    bitmap_set_clear_find_core #(
        .CAPACITY_WORDS (CAPACITY_WORDS),
        .WORD_BITS      (WORD_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    always #6 clk = ~clk;

    // Mirror of the block; the map starts cleared like the block after reset
    bit      map_mirror [0:MAP_BITS-1];
    count_t  ones_total = '0;
    index_t  cfg_lowest;
    index_t  cfg_highest;
    logic    cfg_fill;

    req_word_t req_backlog [$];
    rsp_word_t rsp_due [$];
    req_word_t next_req;
    rsp_word_t want_rsp;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int req_count = 0;
    int rsp_count = 0;
    int search_count = 0;
    int refill_count = 0;
    int setting_count = 0;
    int stall_cycles = 0;

    function automatic longint span_now();
        longint span;
        span = longint'($signed(cfg_highest)) - longint'($signed(cfg_lowest)) + 1;
        if (span < 0)
            span = 0;
        if (span > MAP_BITS)
            span = MAP_BITS;
        return span;
    endfunction

    task automatic bitmap_step(input logic [FUNC_W-1:0] func, input index_t idx);
        rsp_word_t r;
        longint lo_v;
        longint span;
        longint off;
        bit want;
        bit hit;
        lo_v = longint'($signed(cfg_lowest));
        span = span_now();
        r = '0;
        r.status = STATUS_NO_DATA;
        case (func)
            FUNC_GET, FUNC_SET, FUNC_CLEAR:
            begin
                off = longint'($signed(idx)) - lo_v;
                if (off >= 0 && off < span)
                begin
                    r.status = STATUS_OK;
                    if (func == FUNC_GET)
                    begin
                        r.bit_value = map_mirror[off];
                    end
                    else if (func == FUNC_SET)
                    begin
                        if (!map_mirror[off])
                        begin
                            map_mirror[off] = 1'b1;
                            if (ones_total != COUNT_MAX)
                                ones_total = ones_total + 1'b1;
                        end
                    end
                    else if (map_mirror[off])
                    begin
                        map_mirror[off] = 1'b0;
                        if (ones_total != '0)
                            ones_total = ones_total - 1'b1;
                    end
                end
            end
            FUNC_FIND_SET, FUNC_FIND_CLEAR:
            begin
                search_count++;
                want = (func == FUNC_FIND_SET);
                hit = 1'b0;
                off = 0;
                while (!hit && off < span)
                begin
                    if (map_mirror[off] == want)
                        hit = 1'b1;
                    else
                        off++;
                end
                if (hit)
                begin
                    r.status = STATUS_OK;
                    r.found_index = index_t'(lo_v + off);
                end
            end
            FUNC_REFILL:
            begin
                refill_count++;
                // The refill covers the whole store, not just the span
                for (int i = 0; i < MAP_BITS; i++)
                    map_mirror[i] = cfg_fill;
                if (cfg_fill)
                    ones_total = (span > longint'(COUNT_MAX)) ? COUNT_MAX : count_t'(span);
                else
                    ones_total = '0;
                r.status = STATUS_OK;
            end
            default:
            begin
                r.status = STATUS_NO_DATA;
            end
        endcase
        r.ones_count = ones_total;
        rsp_due.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR response %0d: %s is %0d, expected %0d", rsp_count, what, got, want);
        error_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        case (idx)
            REG_LOWEST_BIT:  cfg_lowest = data;
            REG_HIGHEST_BIT: cfg_highest = data;
            REG_FILL_ONES:   cfg_fill = data[0];
            default:         ;
        endcase
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (req_backlog.size() != 0 || rsp_due.size() != 0 || req_ch.valid)
            @(negedge clk);
    endtask

    // Reprogram the range and fill value, then pick the gap profile
    task automatic apply_config(input index_t lo, input index_t hi, input logic fill,
                                input int gap_mode);
        logic [CFG_W-1:0] fill_word;
        wait_idle();
        fill_word = $urandom();
        fill_word[0] = fill;
        write_reg(REG_LOWEST_BIT, lo);
        write_reg(REG_HIGHEST_BIT, hi);
        write_reg(REG_FILL_ONES, fill_word);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (gap_mode)
            1:
            begin
                send_idle_pct = 72;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 72;
            end
            3:
            begin
                send_idle_pct = 17;
                recv_stall_pct = 17;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
        setting_count++;
    endtask

    task automatic push_req(input logic [FUNC_W-1:0] func, input index_t idx);
        req_word_t w;
        w.func = func;
        w.bit_index = idx;
        req_backlog.push_back(w);
    endtask

    function automatic req_word_t rand_req();
        req_word_t w;
        int pick;
        longint span;
        longint lo_v;
        span = span_now();
        lo_v = longint'($signed(cfg_lowest));
        pick = $urandom_range(99);
        if (pick < 24)
            w.func = FUNC_GET;
        else if (pick < 50)
            w.func = FUNC_SET;
        else if (pick < 68)
            w.func = FUNC_CLEAR;
        else if (pick < 78)
            w.func = FUNC_FIND_SET;
        else if (pick < 88)
            w.func = FUNC_FIND_CLEAR;
        else if (pick < 93)
            w.func = FUNC_REFILL;
        else if (pick < 97)
            w.func = FUNC_RSVD_6;
        else
            w.func = FUNC_RSVD_7;
        pick = $urandom_range(99);
        if (pick < 80 && span > 0)
        begin
            w.bit_index = index_t'(lo_v + longint'($urandom_range(32'(span - 1))));
        end
        else if (pick < 90)
        begin
            case ($urandom_range(4))
                0:       w.bit_index = cfg_lowest - 32'd1;
                1:       w.bit_index = cfg_lowest;
                2:       w.bit_index = cfg_highest;
                3:       w.bit_index = cfg_highest + 32'd1;
                default: w.bit_index = index_t'(lo_v + span);
            endcase
        end
        else
        begin
            w.bit_index = $urandom();
        end
        return w;
    endfunction

    // Request driver: record the accepted word, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.func <= FUNC_GET;
            req_ch.bit_index <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                bitmap_step(req_ch.func, req_ch.bit_index);
                req_count++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_backlog.size() != 0 &&
                    (send_idle_pct == 0 || $urandom_range(99) >= send_idle_pct))
                begin
                    next_req = req_backlog.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.func <= next_req.func;
                    req_ch.bit_index <= next_req.bit_index;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: compare against the oldest due word, then pick ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    $display("ERROR response %0d: word arrived with nothing due", rsp_count);
                    error_count++;
                end
                else
                begin
                    want_rsp = rsp_due.pop_front();
                    if (rsp_ch.status !== want_rsp.status)
                        report_mismatch("status", rsp_ch.status, want_rsp.status);
                    if (rsp_ch.bit_value !== want_rsp.bit_value)
                        report_mismatch("bit_value", rsp_ch.bit_value, want_rsp.bit_value);
                    if (rsp_ch.found_index !== want_rsp.found_index)
                        report_mismatch("found_index", $signed(rsp_ch.found_index),
                                        $signed(want_rsp.found_index));
                    if (rsp_ch.ones_count !== want_rsp.ones_count)
                        report_mismatch("ones_count", rsp_ch.ones_count, want_rsp.ones_count);
                end
                rsp_count++;
            end
            rsp_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: %0d cycles without a word moving", stall_cycles);
            $display("FAIL bitmap_set_clear_find_core");
            $finish;
        end
    end

    initial
    begin
        index_t lo;
        index_t hi;
        logic fill;
        int pick;
        cfg_lowest = 32'd0;
        cfg_highest = 32'd4095;
        cfg_fill = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // Hold off until the clearing pass after reset is done
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);

        // Full default range, zero fill
        apply_config(32'd0, 32'd4095, 1'b0, 0);
        push_req(FUNC_GET, 32'd0);
        push_req(FUNC_GET, 32'd4095);
        push_req(FUNC_GET, 32'd4096);
        push_req(FUNC_GET, 32'hFFFF_FFFF);
        push_req(FUNC_GET, 32'h7FFF_FFFF);
        push_req(FUNC_GET, 32'h8000_0000);
        push_req(FUNC_SET, 32'd0);
        push_req(FUNC_SET, 32'd4095);
        push_req(FUNC_SET, 32'd0);
        push_req(FUNC_GET, 32'd0);
        push_req(FUNC_FIND_SET, 32'd0);
        push_req(FUNC_FIND_CLEAR, 32'hFFFF_FFFF);
        push_req(FUNC_CLEAR, 32'd0);
        push_req(FUNC_CLEAR, 32'd0);
        push_req(FUNC_FIND_SET, 32'h5555_5555);
        push_req(FUNC_RSVD_6, 32'd1);
        push_req(FUNC_RSVD_7, 32'd2);
        push_req(FUNC_REFILL, 32'hAAAA_AAAA);
        push_req(FUNC_FIND_SET, 32'd0);

        // Widest signed range: span saturates at capacity, fill with ones
        apply_config(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 0);
        push_req(FUNC_REFILL, 32'd0);
        push_req(FUNC_FIND_CLEAR, 32'd0);
        push_req(FUNC_CLEAR, 32'h8000_0064);
        push_req(FUNC_FIND_CLEAR, 32'd0);
        push_req(FUNC_GET, 32'h8000_0FFF);
        push_req(FUNC_GET, 32'h8000_1000);
        push_req(FUNC_SET, 32'h7FFF_FFFF);

        // Single-bit span, empty span, top of the index space
        apply_config(32'd1000, 32'd1000, 1'b1, 1);
        repeat (RANDOM_PER_PHASE) req_backlog.push_back(rand_req());
        apply_config(32'd10, 32'd9, 1'b1, 2);
        repeat (RANDOM_PER_PHASE) req_backlog.push_back(rand_req());
        apply_config(32'h7FFF_FF00, 32'h7FFF_FFFF, 1'b0, 3);
        repeat (RANDOM_PER_PHASE) req_backlog.push_back(rand_req());

        for (int p = 0; p < 11; p++)
        begin
            pick = $urandom_range(9);
            fill = $urandom_range(1);
            if (pick == 0)
            begin
                lo = $urandom();
                hi = lo + 32'd4095;
            end
            else if (pick == 1)
            begin
                lo = $urandom();
                hi = lo - 32'($urandom_range(1000, 1));
            end
            else
            begin
                lo = (pick < 6) ? 32'($urandom_range(2000)) - 32'd1000 : $urandom();
                hi = lo + 32'($urandom_range(299));
            end
            apply_config(lo, hi, fill, p % 4);
            repeat (RANDOM_PER_PHASE) req_backlog.push_back(rand_req());
        end

        wait_idle();
        // Let trailing cycles pass so a stray response word would show up
        repeat (20) @(posedge clk);

        $display("Ran %0d requests, checked %0d responses over %0d register settings",
                 req_count, rsp_count, setting_count);
        $display("Of these, %0d were searches and %0d refills; %0d mismatches",
                 search_count, refill_count, error_count);
        if (error_count == 0)
            $display("PASS bitmap_set_clear_find_core");
        else
            $display("FAIL bitmap_set_clear_find_core");
        $finish;
    end

endmodule
